// ===== sv/prq_pkg.sv =====
// Package for the priority ready-queue scheduler: constants, codes and payload types.
// No dependencies; used by every module of the block.
package prq_pkg;

    localparam int THREADS_DEF = 8;
    localparam int LEVELS_DEF  = 16;
    localparam int FIFO_DEPTH  = 2;

    typedef enum logic [2:0] {
        ACT_READY   = 3'd0,
        ACT_UNREADY = 3'd1,
        ACT_SETPRIO = 3'd2,
        ACT_PICK    = 3'd3,
        ACT_CREATE  = 3'd4,
        ACT_RELEASE = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ALREADY  = 3'd1,
        ST_NOT_HEAD = 3'd2,
        ST_NONE     = 3'd3,
        ST_NO_SLOT  = 3'd4,
        ST_WRONG    = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] thread_id;
        logic [3:0] priority_req;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] chosen_thread;
        logic [3:0] old_priority;
    } out_item_t;

endpackage

// ===== sv/priority_ready_queue_scheduler.sv =====
// Top level of the priority ready-queue scheduler.
// Depends on prq_pkg, prq_front and prq_back.
//
// One action per cycle: a two-entry command queue takes transactions, the back end executes
// one command each cycle (table lookup, enqueue/dequeue, and priority encoders over level
// heads and free slots) and writes its result into a two-entry result queue. A result reaches
// the outputs once its command has passed the command queue and the result queue, and can
// then be popped; throughput is one action per cycle while pop keeps up. When pop holds off,
// the result queue fills after two results, the command queue after two more; full then stalls push.
module priority_ready_queue_scheduler #(
    parameter int THREADS = prq_pkg::THREADS_DEF,
    parameter int LEVELS  = prq_pkg::LEVELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  prq_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output prq_pkg::out_item_t out_item
);
    logic              cmd_valid, cmd_take;
    prq_pkg::in_item_t cmd_item;

    prq_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .cmd_valid(cmd_valid), .cmd_item(cmd_item), .cmd_take(cmd_take)
    );

    prq_back #(.THREADS(THREADS), .LEVELS(LEVELS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_item(cmd_item),
        .cmd_take(cmd_take), .empty(empty), .pop(pop), .out_item(out_item)
    );

    // a command is only taken when one is queued
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid) else $error("command taken from empty queue");

    // results only appear after a command was executed
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(empty)) |-> $past(cmd_take)) else $error("result without command");
endmodule

// ===== sv/prq_front.sv =====
// Front end: two-entry command queue feeding the back end.
// Depends on prq_pkg.
module prq_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  prq_pkg::in_item_t  in_item,
    output logic               cmd_valid,
    output prq_pkg::in_item_t  cmd_item,
    input  logic               cmd_take
);
    localparam int D = prq_pkg::FIFO_DEPTH;

    prq_pkg::in_item_t  mem_reg [D];
    logic               wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               wr, rd;

    assign full      = (cnt_reg == 2'(D));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_item  = mem_reg[rptr_reg];
    assign wr = push && !full;
    assign rd = cmd_take && cmd_valid;

    // pointer and count update
    always_comb
    begin
        wptr_next = wr ? ~wptr_reg : wptr_reg;
        rptr_next = rd ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(wr) - 2'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end
endmodule

// ===== sv/prq_back.sv =====
// Back end: scheduler tables and one-action-per-cycle execution while the result queue has room.
// Depends on prq_pkg.
module prq_back #(
    parameter int THREADS = prq_pkg::THREADS_DEF,
    parameter int LEVELS  = prq_pkg::LEVELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  prq_pkg::in_item_t  cmd_item,
    output logic               cmd_take,
    output logic               empty,
    input  logic               pop,
    output prq_pkg::out_item_t out_item
);
    localparam int TW = $clog2(THREADS + 1);
    localparam int IW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);
    localparam int D  = prq_pkg::FIFO_DEPTH;
    localparam logic [TW-1:0] EMPTY_MARK = TW'(THREADS);

    logic [TW-1:0] head_reg [LEVELS];
    logic [TW-1:0] tail_reg [LEVELS];
    logic [TW-1:0] link_reg [THREADS];
    logic [LW-1:0] lvl_reg  [THREADS];
    logic [THREADS-1:0] ready_reg, used_reg;

    // result queue
    prq_pkg::out_item_t rq_reg [D];
    logic       rw_reg, rr_reg;
    logic [1:0] rc_reg;
    logic       res_wr, res_rd;
    prq_pkg::out_item_t res;

    assign empty    = (rc_reg == 2'd0);
    assign out_item = rq_reg[rr_reg];
    assign res_rd   = pop && !empty;
    assign cmd_take = cmd_valid && (rc_reg != 2'(D));
    assign res_wr   = cmd_take;

    // decode
    logic [TW-1:0] tid;
    logic [LW-1:0] prio;
    logic          valid;
    logic [LW-1:0] tl;
    logic          t_ready;
    logic [TW-1:0] pick_t;
    logic          pick_ok;
    logic [TW-1:0] free_t;
    logic          free_ok;
    logic          do_enq, do_deq, do_set, do_create, do_rel;
    logic [TW-1:0] enq_t;
    logic [LW-1:0] enq_lv;

    always_comb
    begin
        tid  = TW'(cmd_item.thread_id);
        prio = (32'(cmd_item.priority_req) >= LEVELS) ? LW'(LEVELS - 1)
                                                     : LW'(cmd_item.priority_req);
        valid = (32'(cmd_item.thread_id) < THREADS) && used_reg[tid[IW-1:0]];
        tl      = lvl_reg[tid[IW-1:0]];
        t_ready = ready_reg[tid[IW-1:0]];
        // first non-empty level
        pick_ok = 1'b0;
        pick_t  = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (head_reg[i] != EMPTY_MARK)
            begin
                pick_ok = 1'b1;
                pick_t  = head_reg[i];
            end
        end
        // lowest free slot
        free_ok = 1'b0;
        free_t  = '0;
        for (int i = THREADS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_ok = 1'b1;
                free_t  = TW'(i);
            end
        end
    end

    // action evaluation
    always_comb
    begin
        res       = '0;
        res.status = prq_pkg::ST_WRONG;
        do_enq = 1'b0; do_deq = 1'b0; do_set = 1'b0; do_create = 1'b0; do_rel = 1'b0;
        enq_t  = tid;
        enq_lv = tl;
        case (cmd_item.action)
            prq_pkg::ACT_READY:
            begin
                if (!valid)       res.status = prq_pkg::ST_WRONG;
                else if (t_ready) res.status = prq_pkg::ST_ALREADY;
                else
                begin
                    res.status = prq_pkg::ST_OK;
                    do_enq = 1'b1;
                end
            end
            prq_pkg::ACT_UNREADY:
            begin
                if (!valid) res.status = prq_pkg::ST_WRONG;
                else if (!t_ready || head_reg[tl] != tid) res.status = prq_pkg::ST_NOT_HEAD;
                else
                begin
                    res.status = prq_pkg::ST_OK;
                    do_deq = 1'b1;
                end
            end
            prq_pkg::ACT_SETPRIO:
            begin
                if (!valid) res.status = prq_pkg::ST_WRONG;
                else
                begin
                    res.old_priority = 4'(tl);
                    if (t_ready) res.status = prq_pkg::ST_ALREADY;
                    else
                    begin
                        res.status = prq_pkg::ST_OK;
                        do_set = 1'b1;
                    end
                end
            end
            prq_pkg::ACT_PICK:
            begin
                if (pick_ok)
                begin
                    res.status = prq_pkg::ST_OK;
                    res.chosen_thread = 3'(pick_t);
                end
                else res.status = prq_pkg::ST_NONE;
            end
            prq_pkg::ACT_CREATE:
            begin
                if (free_ok)
                begin
                    res.status = prq_pkg::ST_OK;
                    res.chosen_thread = 3'(free_t);
                    do_create = 1'b1;
                    do_enq = 1'b1;
                    enq_t  = free_t;
                    enq_lv = prio;
                end
                else res.status = prq_pkg::ST_NO_SLOT;
            end
            prq_pkg::ACT_RELEASE:
            begin
                if (!valid || t_ready) res.status = prq_pkg::ST_WRONG;
                else
                begin
                    res.status = prq_pkg::ST_OK;
                    do_rel = 1'b1;
                end
            end
            default: res.status = prq_pkg::ST_WRONG;
        endcase
    end

    // table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= EMPTY_MARK;
                tail_reg[i] <= EMPTY_MARK;
            end
            for (int i = 0; i < THREADS; i++)
            begin
                link_reg[i] <= EMPTY_MARK;
                lvl_reg[i]  <= '0;
            end
            ready_reg <= '0;
            used_reg  <= '0;
        end
        else if (cmd_take)
        begin
            if (do_enq)
            begin
                link_reg[enq_t[IW-1:0]] <= EMPTY_MARK;
                if (tail_reg[enq_lv] != EMPTY_MARK)
                    link_reg[tail_reg[enq_lv][IW-1:0]] <= enq_t;
                else
                    head_reg[enq_lv] <= enq_t;
                tail_reg[enq_lv] <= enq_t;
                ready_reg[enq_t[IW-1:0]] <= 1'b1;
            end
            if (do_create)
            begin
                used_reg[free_t[IW-1:0]] <= 1'b1;
                lvl_reg[free_t[IW-1:0]]  <= prio;
            end
            if (do_deq)
            begin
                head_reg[tl] <= link_reg[tid[IW-1:0]];
                if (link_reg[tid[IW-1:0]] == EMPTY_MARK)
                    tail_reg[tl] <= EMPTY_MARK;
                link_reg[tid[IW-1:0]]  <= EMPTY_MARK;
                ready_reg[tid[IW-1:0]] <= 1'b0;
            end
            if (do_set)
                lvl_reg[tid[IW-1:0]] <= prio;
            if (do_rel)
            begin
                used_reg[tid[IW-1:0]] <= 1'b0;
                lvl_reg[tid[IW-1:0]]  <= '0;
                link_reg[tid[IW-1:0]] <= EMPTY_MARK;
            end
        end
    end

    // result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg <= 1'b0;
            rr_reg <= 1'b0;
            rc_reg <= 2'd0;
        end
        else
        begin
            if (res_wr) rw_reg <= ~rw_reg;
            if (res_rd) rr_reg <= ~rr_reg;
            rc_reg <= rc_reg + 2'(res_wr) - 2'(res_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr)
            rq_reg[rw_reg] <= res;
    end
endmodule
